### src/tvf_pkg.sv
`default_nettype none

package tvf_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SQUEEZE_BLANK    = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  // Byte values used by the filter.
  localparam logic [7:0] ASCII_TAB    = 8'd9;
  localparam logic [7:0] ASCII_NL     = 8'd10;
  localparam logic [7:0] ASCII_SPACE  = 8'd32;
  localparam logic [7:0] ASCII_DOLLAR = 8'd36;
  localparam logic [7:0] ASCII_QMARK  = 8'd63;
  localparam logic [7:0] ASCII_CARET  = 8'd94;
  localparam logic [7:0] ASCII_UPPER_I = 8'd73;
  localparam logic [7:0] ASCII_DEL    = 8'd127;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // Shape of one output run, besides the digits and the final byte.
  typedef struct packed {
    logic number;
    logic dollar;
    logic caret;
  } tvf_flags_t;

endpackage

`default_nettype wire

### src/tvf_emit.sv
`default_nettype none

// Holds one output run and plays it out one byte per transaction.
module tvf_emit #(
  parameter int unsigned NumberDigits = 6
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               load_i,
  input  tvf_pkg::tvf_flags_t               flags_i,
  input  wire  [NumberDigits-1:0][7:0]      digits_i,
  input  wire  [7:0]                        char_i,
  output logic                              can_take_o,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              run_last_o
);
  import tvf_pkg::*;

  localparam int unsigned PW = $clog2(NumberDigits + 4);
  localparam int unsigned DW = $clog2(NumberDigits);
  localparam logic [PW-1:0] POS_TAB    = PW'(NumberDigits);
  localparam logic [PW-1:0] POS_DOLLAR = PW'(NumberDigits + 1);
  localparam logic [PW-1:0] POS_CARET  = PW'(NumberDigits + 2);
  localparam logic [PW-1:0] POS_CHAR   = PW'(NumberDigits + 3);

  logic                         valid_q, valid_d;
  logic [PW-1:0]                pos_q, pos_d;
  tvf_flags_t                   flags_q;
  logic [NumberDigits-1:0][7:0] digits_q;
  logic [7:0]                   char_q;
  logic [PW-1:0]                pos_start;
  logic [PW-1:0]                pos_next;
  logic                         out_done;

  assign run_last_o  = (pos_q == POS_CHAR);
  assign out_valid_o = valid_q;
  assign out_done    = valid_q && !out_stall_i;
  assign can_take_o  = !valid_q || (out_done && run_last_o);

  // First position of a new run.
  always_comb begin
    priority if (flags_i.number) begin
      pos_start = '0;
    end else if (flags_i.dollar) begin
      pos_start = POS_DOLLAR;
    end else if (flags_i.caret) begin
      pos_start = POS_CARET;
    end else begin
      pos_start = POS_CHAR;
    end
  end

  // Step to the next byte of the current run, skipping absent parts.
  always_comb begin
    priority if (pos_q < POS_TAB) begin
      pos_next = pos_q + PW'(1);
    end else if (pos_q == POS_TAB) begin
      pos_next = flags_q.dollar ? POS_DOLLAR : (flags_q.caret ? POS_CARET : POS_CHAR);
    end else if (pos_q == POS_DOLLAR) begin
      pos_next = flags_q.caret ? POS_CARET : POS_CHAR;
    end else begin
      pos_next = POS_CHAR;
    end
  end

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    if (load_i) begin
      valid_d = 1'b1;
      pos_d   = pos_start;
    end else if (out_done) begin
      if (run_last_o) begin
        valid_d = 1'b0;
      end else begin
        pos_d = pos_next;
      end
    end
  end

  // Select the byte at the current position.
  always_comb begin
    priority if (pos_q < POS_TAB) begin
      out_byte_o = digits_q[pos_q[DW-1:0]];
    end else if (pos_q == POS_TAB) begin
      out_byte_o = ASCII_TAB;
    end else if (pos_q == POS_DOLLAR) begin
      out_byte_o = ASCII_DOLLAR;
    end else if (pos_q == POS_CARET) begin
      out_byte_o = ASCII_CARET;
    end else begin
      out_byte_o = char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  // Run payload, captured on load.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q  <= flags_i;
      digits_q <= digits_i;
      char_q   <= char_i;
    end
  end

endmodule

`default_nettype wire

### src/text_view_filter.sv
// The first result byte of a transaction shows in the cycle after it is accepted.
// Output: one byte per cycle while out_stall_i is low. An input yielding k bytes holds
// the output register until all are taken, so plain bytes pass one per cycle and a
// numbered line start adds NUMBER_DIGITS + 1 bytes; a dropped empty line yields none.
// Reset: asynchronous, active low; all options off, line start set, counter at one.
`default_nettype none

module text_view_filter #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [2:0] cfg_index_i,
  input  wire        cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] data_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import tvf_pkg::*;

  localparam int unsigned BW = 4 * NUMBER_DIGITS;

  // Option registers.
  logic number_nonblank_q, number_all_q, show_ends_q;
  logic squeeze_blank_q, show_tabs_q, show_nonprinting_q;

  // Line state.
  logic          at_line_start_q, at_line_start_d;
  logic          prev_blank_q, prev_blank_d;
  logic [BW-1:0] line_bcd_q, line_bcd_d;

  logic                          can_take;
  logic                          in_accept;
  logic                          is_nl, is_tab, drop, do_number;
  logic                          caret_tab, caret_ctl, caret_del;
  logic [7:0]                    main_char;
  tvf_flags_t                    flags;
  logic [NUMBER_DIGITS-1:0][7:0] digit_chars;
  logic [BW-1:0]                 bcd_inc;
  logic                          all_nines;
  logic                          carry;
  logic                          started;

  assign in_stall_o = !can_take;
  assign in_accept  = in_valid_i && can_take;

  assign is_nl     = (data_byte_i == ASCII_NL);
  assign is_tab    = (data_byte_i == ASCII_TAB);
  assign drop      = at_line_start_q && is_nl && squeeze_blank_q && prev_blank_q;
  assign do_number = at_line_start_q &&
                     (number_nonblank_q ? !is_nl : number_all_q);

  // Character translation.
  assign caret_tab = show_tabs_q && is_tab;
  assign caret_ctl = show_nonprinting_q && (data_byte_i < CTRL_LIMIT) && !is_nl && !is_tab;
  assign caret_del = show_nonprinting_q && (data_byte_i == ASCII_DEL);

  always_comb begin
    priority if (caret_tab) begin
      main_char = ASCII_UPPER_I;
    end else if (caret_ctl) begin
      main_char = data_byte_i + CARET_OFFSET;
    end else if (caret_del) begin
      main_char = ASCII_QMARK;
    end else begin
      main_char = data_byte_i;
    end
  end

  assign flags.number = do_number;
  assign flags.dollar = is_nl && show_ends_q;
  assign flags.caret  = caret_tab || caret_ctl || caret_del;

  // Line number as right-aligned text, most significant digit first.
  always_comb begin
    started = 1'b0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if ((line_bcd_q[4*i +: 4] != 4'd0) || (i == 0)) begin
        started = 1'b1;
      end
      digit_chars[NUMBER_DIGITS-1-i] = started ? {ASCII_DIGIT_HI, line_bcd_q[4*i +: 4]}
                                               : ASCII_SPACE;
    end
  end

  // Decimal increment that holds at all nines.
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    bcd_inc   = line_bcd_q;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (line_bcd_q[4*i +: 4] != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (line_bcd_q[4*i +: 4] == 4'd9) begin
          bcd_inc[4*i +: 4] = 4'd0;
        end else begin
          bcd_inc[4*i +: 4] = line_bcd_q[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) begin
      bcd_inc = line_bcd_q;
    end
  end

  // Line state update on each accepted transaction that is not dropped.
  always_comb begin
    at_line_start_d = at_line_start_q;
    prev_blank_d    = prev_blank_q;
    line_bcd_d      = line_bcd_q;
    if (in_accept && !drop) begin
      at_line_start_d = is_nl;
      if (at_line_start_q) begin
        prev_blank_d = is_nl;
      end
      if (do_number) begin
        line_bcd_d = bcd_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      prev_blank_q    <= 1'b0;
      line_bcd_q      <= BW'(1);
    end else begin
      at_line_start_q <= at_line_start_d;
      prev_blank_q    <= prev_blank_d;
      line_bcd_q      <= line_bcd_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_nonblank_q  <= 1'b0;
      number_all_q       <= 1'b0;
      show_ends_q        <= 1'b0;
      squeeze_blank_q    <= 1'b0;
      show_tabs_q        <= 1'b0;
      show_nonprinting_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUMBER_NONBLANK:  number_nonblank_q  <= cfg_data_i;
        CFG_NUMBER_ALL:       number_all_q       <= cfg_data_i;
        CFG_SHOW_ENDS:        show_ends_q        <= cfg_data_i;
        CFG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_data_i;
        CFG_SHOW_TABS:        show_tabs_q        <= cfg_data_i;
        CFG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output run register and sequencer.
  tvf_emit #(
    .NumberDigits(NUMBER_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept && !drop),
    .flags_i     (flags),
    .digits_i    (digit_chars),
    .char_i      (main_char),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

### src/tvf_checker.sv
`default_nettype none

module tvf_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] out_byte_o,
  input wire       run_last_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // With nothing pending at the output, input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // Input waits until the current run reaches its last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> in_stall_o)
    else $error("input accepted in the middle of a run");

  // A run continues after a byte that is not its last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("run ended early");

  // Without a new transaction, the output empties after the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && run_last_o && !in_valid_i |=> !out_valid_o)
    else $error("result appeared without a transaction");

endmodule

bind text_view_filter tvf_checker u_tvf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o)
);

`default_nettype wire

### tb/sv/tb_text_view_filter.sv
module tb_text_view_filter;
  import tvf_pkg::*;

  // Six digits is the counter width that the line numbers are defined with.
  localparam int unsigned DIGITS = 6;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned IDLE_PCT = 34;
  localparam int unsigned CYCLE_LIMIT = 40000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASE_BYTES = 12;

  typedef struct packed {
    logic [7:0] shown;
    logic       last;
  } shown_byte_t;

  typedef logic [7:0] text_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_index = CFG_NUMBER_NONBLANK;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  // Filter options and line state as the predictor sees them.
  logic opt_nonblank = 1'b0;
  logic opt_all = 1'b0;
  logic opt_ends = 1'b0;
  logic opt_squeeze = 1'b0;
  logic opt_tabs = 1'b0;
  logic opt_nonprint = 1'b0;
  logic line_start = 1'b1;
  logic prev_blank = 1'b0;
  logic [4*DIGITS-1:0] line_bcd = 1;

  shown_byte_t expected_shown[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic        quiet = 1'b0;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;

  text_view_filter #(
    .NUMBER_DIGITS(DIGITS)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .run_last_o  (run_last)
  );

  always #1 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_view_filter verification failed");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("[%0d] %s", cycle_count, msg);
    end
    fail_count++;
  endtask

  // Advance the BCD line counter; it sticks once every digit is nine.
  task automatic bump_line_number();
    logic carry;
    logic [3:0] d;
    carry = 1'b1;
    if (line_bcd == {DIGITS{4'h9}}) begin
      return;
    end
    for (int k = 0; k < DIGITS; k++) begin
      d = line_bcd[4*k +: 4];
      if (carry) begin
        if (d == 4'h9) begin
          line_bcd[4*k +: 4] = 4'h0;
        end else begin
          line_bcd[4*k +: 4] = d + 4'h1;
          carry = 1'b0;
        end
      end
    end
  endtask

  function automatic shown_byte_t plain(input logic [7:0] b);
    shown_byte_t s;
    s.shown = b;
    s.last = 1'b0;
    return s;
  endfunction

  // Work out the display bytes for one accepted input byte.
  task automatic predict_display_run(input logic [7:0] c);
    shown_byte_t run[$];
    logic is_nl;
    logic started;
    logic [3:0] d;
    is_nl = (c == ASCII_NL);

    if (line_start) begin
      // A repeated empty line is dropped without touching any state.
      if (is_nl && opt_squeeze && prev_blank) begin
        return;
      end
      prev_blank = is_nl;
      if (opt_nonblank ? !is_nl : opt_all) begin
        started = 1'b0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
          d = line_bcd[4*k +: 4];
          if (d != 4'h0 || k == 0) begin
            started = 1'b1;
          end
          run.push_back(plain(started ? {ASCII_DIGIT_HI, d} : ASCII_SPACE));
        end
        run.push_back(plain(ASCII_TAB));
        bump_line_number();
      end
    end

    if (is_nl && opt_ends) begin
      run.push_back(plain(ASCII_DOLLAR));
    end

    if (opt_tabs && c == ASCII_TAB) begin
      run.push_back(plain(ASCII_CARET));
      run.push_back(plain(ASCII_UPPER_I));
    end else if (opt_nonprint && c < CTRL_LIMIT && !is_nl && c != ASCII_TAB) begin
      run.push_back(plain(ASCII_CARET));
      run.push_back(plain(c + CARET_OFFSET));
    end else if (opt_nonprint && c == ASCII_DEL) begin
      run.push_back(plain(ASCII_CARET));
      run.push_back(plain(ASCII_QMARK));
    end else begin
      run.push_back(plain(c));
    end

    line_start = is_nl;
    run[run.size() - 1].last = 1'b1;
    foreach (run[k]) begin
      expected_shown.push_back(run[k]);
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it, and predict on acceptance.
  task automatic send_byte(input logic [7:0] c);
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    data_byte = c;
    forever begin
      @(posedge clk);
      if (!in_stall) begin
        break;
      end
    end
    predict_display_run(c);
  endtask

  task automatic send_run(input text_q_t s);
    foreach (s[k]) begin
      send_byte(s[k]);
    end
  endtask

  // Wait until every expected byte has come out and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_shown.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_option(input cfg_idx_e idx, input logic val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_NUMBER_NONBLANK:  opt_nonblank = val;
      CFG_NUMBER_ALL:       opt_all = val;
      CFG_SHOW_ENDS:        opt_ends = val;
      CFG_SQUEEZE_BLANK:    opt_squeeze = val;
      CFG_SHOW_TABS:        opt_tabs = val;
      CFG_SHOW_NONPRINTING: opt_nonprint = val;
      default: ;
    endcase
  endtask

  function automatic logic [5:0] opt_set(input logic nonblank, input logic all,
                                         input logic ends, input logic squeeze,
                                         input logic tabs, input logic nonprint);
    logic [5:0] v;
    v = '0;
    v[CFG_NUMBER_NONBLANK] = nonblank;
    v[CFG_NUMBER_ALL] = all;
    v[CFG_SHOW_ENDS] = ends;
    v[CFG_SQUEEZE_BLANK] = squeeze;
    v[CFG_SHOW_TABS] = tabs;
    v[CFG_SHOW_NONPRINTING] = nonprint;
    return v;
  endfunction

  // Options change only once the block has gone idle.
  task automatic configure(input logic [5:0] v);
    drain();
    write_option(CFG_NUMBER_NONBLANK, v[CFG_NUMBER_NONBLANK]);
    write_option(CFG_NUMBER_ALL, v[CFG_NUMBER_ALL]);
    write_option(CFG_SHOW_ENDS, v[CFG_SHOW_ENDS]);
    write_option(CFG_SQUEEZE_BLANK, v[CFG_SQUEEZE_BLANK]);
    write_option(CFG_SHOW_TABS, v[CFG_SHOW_TABS]);
    write_option(CFG_SHOW_NONPRINTING, v[CFG_SHOW_NONPRINTING]);
  endtask

  // Text-like byte mix: printable bytes most often, with frequent line ends and some
  // tabs, control bytes, delete and high bytes.
  function automatic logic [7:0] random_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(126, 32));
    if (r < 65) return ASCII_NL;
    if (r < 73) return ASCII_TAB;
    if (r < 83) return 8'($urandom_range(31, 0));
    if (r < 88) return ASCII_DEL;
    return 8'($urandom_range(255, 128));
  endfunction

  // Receiver side: random stalls, a long hold-off on request, none when quiet.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each transaction on the output with the oldest expected byte.
  always @(posedge clk) begin
    shown_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_shown.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b", out_byte, run_last));
      end else begin
        want = expected_shown.pop_front();
        if (out_byte !== want.shown || run_last !== want.last) begin
          note_failure($sformatf("byte %02h last %0b, expected byte %02h last %0b",
                                 out_byte, run_last, want.shown, want.last));
        end
      end
    end
  end

  // Bytes with all options off, field extremes included.
  task automatic test_plain_bytes();
    configure(opt_set(0, 0, 0, 0, 0, 0));
    send_run('{8'h00, 8'hFF, 8'h41, ASCII_TAB, ASCII_DEL, ASCII_NL});
  endtask

  // Numbering of every line, then both numbering options where nonblank wins.
  task automatic test_line_numbers();
    configure(opt_set(0, 1, 1, 0, 0, 0));
    send_run('{8'h78, ASCII_NL, ASCII_NL});
    configure(opt_set(1, 1, 0, 0, 0, 0));
    send_run('{ASCII_NL, 8'h71, ASCII_NL});
  endtask

  // Caret notation; a tab passes unchanged when only nonprinting is shown.
  task automatic test_caret_notation();
    configure(opt_set(0, 0, 0, 0, 1, 1));
    send_run('{ASCII_TAB, 8'h01, 8'h1F, ASCII_DEL, 8'h80, ASCII_NL});
    configure(opt_set(0, 0, 0, 0, 0, 1));
    send_run('{ASCII_TAB, 8'h00});
  endtask

  // Repeated empty lines are dropped and not numbered.
  task automatic test_squeeze_blank();
    configure(opt_set(0, 1, 0, 1, 0, 0));
    send_run('{ASCII_NL, ASCII_NL, ASCII_NL, 8'h7A, ASCII_NL});
  endtask

  // The receiver holds off while the sender keeps offering long runs.
  task automatic test_receiver_hold();
    configure(opt_set(0, 1, 1, 0, 1, 1));
    quiet = 1'b1;
    hold_request = 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_byte((k % 3 == 0) ? ASCII_NL : random_text_byte());
    end
    quiet = 1'b0;
  endtask

  // Random text under several option settings, the extremes first.
  task automatic test_random_text();
    logic [5:0] v;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        v = '0;
      end else if (phase == 1) begin
        v = '1;
      end else begin
        v = 6'($urandom_range(63));
      end
      configure(v);
      for (int k = 0; k < PHASE_BYTES; k++) begin
        send_byte(random_text_byte());
      end
    end
  endtask

  // Count lines across a decimal carry, then keep numbering under other options.
  task automatic test_counter_carry();
    configure(opt_set(0, 1, 0, 0, 0, 0));
    quiet = 1'b1;
    while (line_bcd[3:0] != 4'h9) begin
      send_byte(ASCII_NL);
    end
    send_byte(ASCII_NL);
    send_byte(8'h62);
    quiet = 1'b0;
    configure(opt_set(1, 0, 1, 0, 0, 0));
    send_run('{8'h77, ASCII_NL, ASCII_NL, 8'h61, ASCII_NL});
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_bytes();
    test_line_numbers();
    test_caret_notation();
    test_squeeze_blank();
    test_receiver_hold();
    test_random_text();
    test_counter_carry();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_view_filter verification clean");
    end else begin
      $display("text_view_filter verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/tvf_pkg.sv
src/tvf_emit.sv
src/text_view_filter.sv
src/tvf_checker.sv
tb/sv/tb_text_view_filter.sv
